FILE: rtl/aes_pkg.sv
package aes_pkg;

  localparam int unsigned KeyWords   = 4;
  localparam int unsigned RoundCount = 10;
  localparam int unsigned TableDepth = 4 * (RoundCount + 1);
  localparam int unsigned TableAw    = $clog2(TableDepth);
  localparam int unsigned RoundW     = $clog2(RoundCount + 1);
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [CfgIdxW-1:0] RegKeyA = 2'd0;
  localparam logic [CfgIdxW-1:0] RegKeyB = 2'd1;
  localparam logic [CfgIdxW-1:0] RegKeyC = 2'd2;
  localparam logic [CfgIdxW-1:0] RegKeyD = 2'd3;

  localparam logic FuncEncrypt = 1'b0;
  localparam logic FuncDecrypt = 1'b1;

  // multiply by x in GF(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] acc;
    logic [7:0] p;
    acc = '0;
    p   = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) acc = acc ^ p;
      p = xtime(p);
    end
    gf_mul = acc;
  endfunction

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

FILE: rtl/aes_block_encrypt_decrypt.sv
// each of the RoundCount+1 round steps between input transfer and result valid reads its
//   four key words from the table (registered read), then passes the state through
//   the shared round unit
// first block after reset or a key write expands the schedule first, into all TableDepth = 44 table words
// one block at a time: a new block is taken only in the idle state, after the previous result transfer; stalls delay it
// reset: key registers cleared, schedule invalid, block idle and ready for a transfer
module aes_block_encrypt_decrypt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [63:0] block_upper_i,
  input  logic [63:0] block_lower_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_upper_o,
  output logic [63:0] result_lower_o
);
  import aes_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StExp  = 3'd1;
  localparam logic [2:0] StLoad = 3'd2;
  localparam logic [2:0] StRnd  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0]  st_q, st_d;
  logic [63:0] key_q [4];
  logic        ready_q;
  logic        dec_q;
  logic [127:0] state_q;
  logic [RoundW-1:0] rnd_q;
  logic [1:0]  col_q;
  logic [TableAw-1:0] widx_q;
  logic [7:0]  rc_q;
  logic [31:0] win_q [KeyWords];
  logic [95:0] rk_q;
  logic [TableAw-1:0] raddr;
  logic [31:0] rdata;
  logic        we;
  logic [31:0] wdata;
  logic [31:0] t;
  logic [127:0] rnd_out;
  logic        fetch_q;

  // key schedule word: uses a sliding window of the last KeyWords words
  always_comb begin
    t = win_q[KeyWords-1];
    if ((widx_q % TableAw'(KeyWords)) == '0)
      t = sub_word({t[23:0], t[31:24]}) ^ {rc_q, 24'h0};
    else if (KeyWords > 6 && (widx_q % TableAw'(KeyWords)) == TableAw'(4))
      t = sub_word(t);
    if (widx_q < TableAw'(KeyWords))
      wdata = widx_q[0] ? key_q[widx_q[2:1]][31:0] : key_q[widx_q[2:1]][63:32];
    else wdata = win_q[0] ^ t;
  end
  assign we = (st_q == StExp);

  // round key column fetch: rnd_q picks the round, col_q the column
  always_comb begin
    raddr = TableAw'({rnd_q, col_q});
  end

  aes_ram #(.Width(32), .Depth(TableDepth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(widx_q), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // key round 0 is a plain key addition, key round RoundCount skips the column mix
  aes_round u_round (
    .dec_i(dec_q), .first_i(rnd_q == RoundW'(0)),
    .last_i(rnd_q == RoundW'(RoundCount)),
    .state_i(state_q), .key_i({rk_q, rdata}), .state_o(rnd_out)
  );

  assign in_stall_o  = (st_q != StIdle);
  assign out_valid_o = (st_q == StOut);
  assign result_upper_o = state_q[127:64];
  assign result_lower_o = state_q[63:0];

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (in_valid_i) st_d = ready_q ? StLoad : StExp;
      StExp:  if (widx_q == TableAw'(TableDepth-1)) st_d = StLoad;
      StLoad: if (fetch_q) st_d = StRnd;
      StRnd:  if (fetch_q && rnd_q == (dec_q ? RoundW'(0) : RoundW'(RoundCount))) st_d = StOut;
      StOut:  if (!out_stall_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      ready_q <= 1'b0;
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        key_q[cfg_index_i] <= cfg_data_i;
        ready_q <= 1'b0;
      end else if (st_q == StExp && st_d == StLoad) begin
        ready_q <= 1'b1;
      end
    end
  end

  // datapath: three reads fill rk_q, the fourth word goes straight to the round unit
  always_ff @(posedge clk_i) begin
    if (st_q == StIdle) begin
      dec_q   <= (func_i == FuncDecrypt);
      state_q <= {block_upper_i, block_lower_i};
      widx_q  <= '0;
      rc_q    <= 8'h01;
      col_q   <= '0;
      fetch_q <= 1'b0;
      rnd_q   <= (func_i == FuncDecrypt) ? RoundW'(RoundCount) : '0;
    end else if (st_q == StExp) begin
      widx_q <= widx_q + 1'b1;
      for (int i = 0; i < KeyWords-1; i++) win_q[i] <= win_q[i+1];
      win_q[KeyWords-1] <= wdata;
      if (widx_q >= TableAw'(KeyWords) && (widx_q % TableAw'(KeyWords)) == '0)
        rc_q <= xtime(rc_q);
    end else if (st_q == StLoad || st_q == StRnd) begin
      // reads are registered: column col arrives through the RAM output register
      if (fetch_q) begin
        state_q <= rnd_out;
        fetch_q <= 1'b0;
        col_q <= '0;
        rnd_q <= dec_q ? rnd_q - 1'b1 : rnd_q + 1'b1;
      end else begin
        if (col_q != 2'd0) rk_q <= {rk_q[63:0], rdata};
        col_q <= col_q + 1'b1;
        if (col_q == 2'd3) fetch_q <= 1'b1;
      end
    end
  end
endmodule

FILE: rtl/aes_ram.sv
module aes_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 44
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // one write port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: rtl/aes_round.sv
module aes_round (
  input  logic         dec_i,
  input  logic         first_i,
  input  logic         last_i,
  input  logic [127:0] state_i,
  input  logic [127:0] key_i,
  output logic [127:0] state_o
);
  import aes_pkg::*;

  logic [7:0] b   [16];
  logic [7:0] s   [16];
  logic [7:0] sh  [16];
  logic [7:0] m   [16];
  logic [7:0] k   [16];
  logic [7:0] x   [16];
  logic [7:0] o   [16];

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      b[i] = state_i[127-8*i -: 8];
      k[i] = key_i[127-8*i -: 8];
    end
    // encrypt: sub, shift, mix, add key
    for (int i = 0; i < 16; i++) s[i] = SBOX[b[i]];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) sh[c*4+r] = s[((c+r)%4)*4+r];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        m[c*4+r] = gf_mul(sh[c*4+r], 4'h2) ^ gf_mul(sh[c*4+(r+1)%4], 4'h3)
                 ^ sh[c*4+(r+2)%4] ^ sh[c*4+(r+3)%4];
    // decrypt: add key, inverse mix, inverse shift, inverse sub
    for (int i = 0; i < 16; i++) x[i] = b[i] ^ k[i];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        o[c*4+r] = gf_mul(x[c*4+r], 4'he) ^ gf_mul(x[c*4+(r+1)%4], 4'hb)
                 ^ gf_mul(x[c*4+(r+2)%4], 4'hd) ^ gf_mul(x[c*4+(r+3)%4], 4'h9);
    for (int i = 0; i < 128; i++) state_o[i] = 1'b0;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        if (first_i) begin
          state_o[127-8*(c*4+r) -: 8] = x[c*4+r];
        end else if (!dec_i) begin
          state_o[127-8*(c*4+r) -: 8] = (last_i ? sh[c*4+r] : m[c*4+r]) ^ k[c*4+r];
        end else begin
          // inverse shift moves row r right by r, then inverse sbox
          state_o[127-8*(((c+r)%4)*4+r) -: 8] =
            INV_SBOX[last_i ? x[c*4+r] : o[c*4+r]];
        end
      end
  end
endmodule

FILE: dv/tb_aes_block_encrypt_decrypt.sv
`timescale 1ns / 1ps

module tb_aes_block_encrypt_decrypt;
  import aes_pkg::*;

  typedef struct {
    logic        func;
    logic [63:0] upper;
    logic [63:0] lower;
  } cipher_req_t;

  typedef struct {
    logic [63:0] upper;
    logic [63:0] lower;
  } cipher_block_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        func;
  logic [63:0] block_upper;
  logic [63:0] block_lower;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] result_upper;
  logic [63:0] result_lower;

  cipher_req_t   pending_blocks[$];
  cipher_block_t expected_blocks[$];

  // predictor copy of the key and schedule
  logic [63:0] key_regs[4];
  logic [31:0] round_keys[TableDepth];
  logic        keys_expanded;
  logic [7:0]  fwd_sub[256];
  logic [7:0]  inv_sub[256];

  int mismatch_cnt;
  int accepted_cnt;
  int checked_cnt;
  int decrypt_cnt;
  int key_phase_cnt;

  aes_block_encrypt_decrypt uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (func),
    .block_upper_i  (block_upper),
    .block_lower_i  (block_lower),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_upper_o (result_upper),
    .result_lower_o (result_lower)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // GF(2^8) arithmetic for the predictor
  function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
    end
    return acc;
  endfunction

  function automatic logic [7:0] gf_recip(input logic [7:0] x);
    logic [7:0] r;
    logic [7:0] p;
    r = 8'h01;
    p = x;
    for (int e = 254; e != 0; e >>= 1) begin
      if (e[0]) r = gf_times(r, p);
      p = gf_times(p, p);
    end
    return r;
  endfunction

  // substitution tables derived from the field inverse and the affine map
  initial begin
    logic [7:0] v;
    for (int x = 0; x < 256; x++) begin
      v = gf_recip(x[7:0]);
      fwd_sub[x] = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]}
                   ^ {v[3:0], v[7:4]} ^ 8'h63;
    end
    for (int x = 0; x < 256; x++) inv_sub[fwd_sub[x]] = x[7:0];
  end

  function automatic logic [31:0] sub_bytes32(input logic [31:0] w);
    return {fwd_sub[w[31:24]], fwd_sub[w[23:16]], fwd_sub[w[15:8]], fwd_sub[w[7:0]]};
  endfunction

  // key schedule from the current key registers
  task automatic expand_round_keys();
    logic [31:0] t;
    logic [7:0]  rcon;
    int          k;
    rcon = 8'h01;
    for (int i = 0; i < TableDepth; i++) begin
      if (i < KeyWords) begin
        k = i;
        round_keys[i] = (k >= 8) ? 32'h0 :
                        (k[0] ? key_regs[k >> 1][31:0] : key_regs[k >> 1][63:32]);
      end else begin
        t = round_keys[i - 1];
        if (i % KeyWords == 0) begin
          t = sub_bytes32({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
          rcon = gf_times(rcon, 8'h02);
        end else if (KeyWords > 6 && i % KeyWords == 4) begin
          t = sub_bytes32(t);
        end
        round_keys[i] = round_keys[i - KeyWords] ^ t;
      end
    end
    keys_expanded = 1'b1;
  endtask

  function automatic void add_key(ref logic [7:0] st[16], input int rnd);
    logic [31:0] w;
    for (int c = 0; c < 4; c++) begin
      w = round_keys[(rnd * 4 + c) % TableDepth];
      st[c*4+0] ^= w[31:24];
      st[c*4+1] ^= w[23:16];
      st[c*4+2] ^= w[15:8];
      st[c*4+3] ^= w[7:0];
    end
  endfunction

  function automatic void substitute(ref logic [7:0] st[16], input logic inverse);
    for (int i = 0; i < 16; i++) st[i] = inverse ? inv_sub[st[i]] : fwd_sub[st[i]];
  endfunction

  function automatic void rotate_rows(ref logic [7:0] st[16], input logic inverse);
    logic [7:0] old[16];
    old = st;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inverse) st[((c + r) % 4) * 4 + r] = old[c*4+r];
        else         st[c*4+r] = old[((c + r) % 4) * 4 + r];
      end
    end
  endfunction

  function automatic void mix_words(ref logic [7:0] st[16], input logic inverse);
    logic [7:0] coef[4];
    logic [7:0] col[4];
    logic [7:0] v;
    if (inverse) coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else         coef = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) col[k] = st[c*4+k];
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int k = 0; k < 4; k++) v ^= gf_times(col[k], coef[(k + 4 - r) % 4]);
        st[c*4+r] = v;
      end
    end
  endfunction

  // cipher one accepted block and queue the expected output
  task automatic predict_cipher(input logic f, input logic [63:0] up, input logic [63:0] lo);
    logic [7:0]    st[16];
    cipher_block_t res;
    if (!keys_expanded) expand_round_keys();
    for (int i = 0; i < 8; i++) begin
      st[i]   = up[63 - 8*i -: 8];
      st[8+i] = lo[63 - 8*i -: 8];
    end
    if (f == FuncEncrypt) begin
      add_key(st, 0);
      for (int rnd = 1; rnd < RoundCount; rnd++) begin
        substitute(st, 1'b0);
        rotate_rows(st, 1'b0);
        mix_words(st, 1'b0);
        add_key(st, rnd);
      end
      substitute(st, 1'b0);
      rotate_rows(st, 1'b0);
      add_key(st, RoundCount);
    end else begin
      add_key(st, RoundCount);
      rotate_rows(st, 1'b1);
      substitute(st, 1'b1);
      for (int rnd = RoundCount - 1; rnd > 0; rnd--) begin
        add_key(st, rnd);
        mix_words(st, 1'b1);
        rotate_rows(st, 1'b1);
        substitute(st, 1'b1);
      end
      add_key(st, 0);
    end
    for (int i = 0; i < 8; i++) begin
      res.upper[63 - 8*i -: 8] = st[i];
      res.lower[63 - 8*i -: 8] = st[8+i];
    end
    expected_blocks.push_back(res);
  endtask

  // idle-free window in the middle of the random part
  function automatic logic no_idle_window();
    return accepted_cnt >= 600 && accepted_cnt < 760;
  endfunction

  // input driver
  always @(posedge clk_i) begin
    cipher_req_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_cipher(func, block_upper, block_lower);
        accepted_cnt++;
        if (func == FuncDecrypt) decrypt_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_blocks.size() > 0 && (no_idle_window() || $urandom_range(99) >= 19)) begin
          nxt = pending_blocks.pop_front();
          in_valid    <= 1'b1;
          func        <= nxt.func;
          block_upper <= nxt.upper;
          block_lower <= nxt.lower;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output stall, with one long hold-off so the input backs up
  always @(posedge clk_i) begin
    int  hold_left;
    logic hold_done;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && accepted_cnt >= 400) begin
      hold_done = 1'b1;
      hold_left = 300;
      out_stall <= 1'b1;
    end else begin
      out_stall <= no_idle_window() ? 1'b0 : ($urandom_range(99) < 19);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    cipher_block_t exp_blk;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_blocks.size() == 0) begin
        $error("result transfer with nothing expected: %h %h", result_upper, result_lower);
        mismatch_cnt++;
      end else begin
        exp_blk = expected_blocks.pop_front();
        checked_cnt++;
        if (result_upper !== exp_blk.upper) begin
          $error("result_upper expected %h actual %h", exp_blk.upper, result_upper);
          mismatch_cnt++;
        end
        if (result_lower !== exp_blk.lower) begin
          $error("result_lower expected %h actual %h", exp_blk.lower, result_lower);
          mismatch_cnt++;
        end
      end
    end
  end

  task automatic queue_block(input logic f, input logic [63:0] up, input logic [63:0] lo);
    cipher_req_t r;
    r.func  = f;
    r.upper = up;
    r.lower = lo;
    pending_blocks.push_back(r);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // wait until every transfer is done, then let the block settle
  task automatic wait_drained();
    while (pending_blocks.size() > 0 || in_valid || expected_blocks.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic load_key(input logic [63:0] ka, input logic [63:0] kb,
                          input logic [63:0] kc, input logic [63:0] kd);
    logic [1:0]  idx[4];
    logic [63:0] val[4];
    idx = '{RegKeyA, RegKeyB, RegKeyC, RegKeyD};
    val = '{ka, kb, kc, kd};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk_i);
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      key_regs[idx[i]] = val[i];
      keys_expanded = 1'b0;
    end
    @(posedge clk_i);
    cfg_we <= 1'b0;
    key_phase_cnt++;
  endtask

  task automatic queue_both(input logic [63:0] up, input logic [63:0] lo);
    queue_block(FuncEncrypt, up, lo);
    queue_block(FuncDecrypt, up, lo);
  endtask

  // stimulus
  initial begin
    logic [63:0] pat;
    int          n;
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = RegKeyA;
    cfg_data     = '0;
    in_valid     = 1'b0;
    out_stall    = 1'b0;
    func         = FuncEncrypt;
    block_upper  = '0;
    block_lower  = '0;
    mismatch_cnt = 0;
    accepted_cnt = 0;
    checked_cnt  = 0;
    decrypt_cnt  = 0;
    key_phase_cnt = 0;
    keys_expanded = 1'b0;
    for (int i = 0; i < 4; i++) key_regs[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset key, schedule built on first block
    queue_both(64'h0, 64'h0);
    queue_both('1, '1);
    wait_drained();

    // standard test vector and bit patterns
    load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f, rand64(), rand64());
    queue_block(FuncEncrypt, 64'h0011223344556677, 64'h8899aabbccddeeff);
    queue_block(FuncDecrypt, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    queue_both(64'h0, 64'h0);
    queue_both('1, '1);
    queue_both(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    queue_both(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    wait_drained();

    // extreme keys
    load_key('1, '1, '1, '1);
    queue_both(64'h0, 64'h0);
    queue_both('1, '1);
    queue_both(64'h8000000000000001, 64'h0123456789abcdef);
    wait_drained();
    load_key('0, '0, '0, '0);
    queue_both(64'h0, 64'h8000000000000000);
    queue_both(64'h0000000000000001, '1);
    wait_drained();

    // random keys, random blocks
    for (int ph = 0; ph < 8; ph++) begin
      load_key(rand64(), rand64(), rand64(), rand64());
      n = $urandom_range(120, 160);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(9))
          0:       pat = '0;
          1:       pat = '1;
          default: pat = rand64();
        endcase
        queue_block(1'($urandom_range(1)), pat, rand64());
      end
      wait_drained();
    end

    $display("checked %0d blocks (%0d decrypt) across %0d key settings",
             checked_cnt, decrypt_cnt, key_phase_cnt + 1);
    if (mismatch_cnt == 0 && expected_blocks.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("timeout after %0d blocks checked", checked_cnt);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: sim.f
rtl/aes_pkg.sv
rtl/aes_ram.sv
rtl/aes_round.sv
rtl/aes_block_encrypt_decrypt.sv
dv/tb_aes_block_encrypt_decrypt.sv
